// ===== rtl/dfr_pkg.sv =====
// Shared types and constants for the delimited frame receiver.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package dfr_pkg;

    // item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // frame layout
    localparam logic [7:0] START_BYTE  = 8'h32;
    localparam logic [7:0] END_BYTE    = 8'h34;
    localparam logic [3:0] LAST_POS    = 4'd13;
    localparam logic [7:0] TEMP_OFFSET = 8'd55;
    localparam logic [4:0] SWING_BITS  = 5'b11111;

    // result status codes
    localparam logic [2:0] ST_MATCH    = 3'd0;
    localparam logic [2:0] ST_OTHER    = 3'd1;
    localparam logic [2:0] ST_CHECKSUM = 3'd2;
    localparam logic [2:0] ST_NO_END   = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    // register indexes
    localparam logic [1:0] REG_TIMEOUT     = 2'd0;
    localparam logic [1:0] REG_MATCH_SRC   = 2'd1;
    localparam logic [1:0] REG_MATCH_DST   = 2'd2;
    localparam logic [1:0] REG_MATCH_CMD   = 2'd3;

    // register reset values
    localparam logic [15:0] RST_TIMEOUT   = 16'd500;
    localparam logic [7:0]  RST_MATCH_SRC = 8'h20;
    localparam logic [7:0]  RST_MATCH_DST = 8'h84;
    localparam logic [7:0]  RST_MATCH_CMD = 8'h52;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        frame_source;
        logic [7:0]        frame_destination;
        logic [7:0]        frame_command;
        logic signed [7:0] set_temperature;
        logic signed [7:0] room_temperature;
        logic signed [7:0] outlet_temperature;
        logic [2:0]        fan_speed;
        logic              swing_on;
        logic              power_on;
        logic [3:0]        control_type;
    } result_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  match_source;
        logic [7:0]  match_destination;
        logic [7:0]  match_command;
    } cfg_t;

    function automatic logic signed [7:0] temp_of(input logic [7:0] b);
        temp_of = signed'({1'b0, b[6:0]} - TEMP_OFFSET);
    endfunction

endpackage

// ===== rtl/dfr_cfg_regs.sv =====
// Configuration register file: timeout and address/command match values.
// Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output dfr_pkg::cfg_t      cfg
);
    import dfr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks     <= RST_TIMEOUT;
            cfg_reg.match_source      <= RST_MATCH_SRC;
            cfg_reg.match_destination <= RST_MATCH_DST;
            cfg_reg.match_command     <= RST_MATCH_CMD;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TIMEOUT:   cfg_reg.timeout_ticks     <= cfg_data;
                REG_MATCH_SRC: cfg_reg.match_source      <= cfg_data[7:0];
                REG_MATCH_DST: cfg_reg.match_destination <= cfg_data[7:0];
                REG_MATCH_CMD: cfg_reg.match_command     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dfr_frame_engine.sv =====
// Frame tracking state, running XOR, byte stores and the end-of-frame decode.
// Depends on dfr_pkg; fed from the input stage, feeds the result buffer.
`timescale 1ns / 1ps

module dfr_frame_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  dfr_pkg::item_t    item,
    input  dfr_pkg::cfg_t     cfg,
    output logic              res_push,
    output dfr_pkg::result_t  res
);
    import dfr_pkg::*;

    logic        in_frame_reg,   in_frame_next;
    logic [3:0]  count_reg,      count_next;
    logic [7:0]  xor_reg,        xor_next;
    logic [15:0] idle_reg,       idle_next;
    logic [7:0]  header_reg [3];
    logic [7:0]  header_next [3];
    logic [7:0]  payload_reg [5];
    logic [7:0]  payload_next [5];
    logic [7:0]  check_reg,      check_next;

    logic        produce;
    result_t     res_c;
    logic        addr_match;

    assign addr_match = (header_reg[0] == cfg.match_source)
                     && (header_reg[1] == cfg.match_destination)
                     && (header_reg[2] == cfg.match_command);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        idle_next     = idle_reg;
        header_next   = header_reg;
        payload_next  = payload_reg;
        check_next    = check_reg;
        produce       = 1'b0;
        res_c         = '0;

        if (item.func == FUNC_TICK)
        begin
            idle_next = (idle_reg != '1) ? idle_reg + 16'd1 : idle_reg;
            if (in_frame_reg && (idle_next >= cfg.timeout_ticks))
            begin
                in_frame_next = 1'b0;
                count_next    = '0;
                produce       = 1'b1;
                res_c.status  = ST_TIMEOUT;
            end
        end
        else
        begin
            idle_next = '0;
            if (!in_frame_reg)
            begin
                if (item.rx_byte == START_BYTE)
                begin
                    in_frame_next = 1'b1;
                    count_next    = 4'd1;
                    xor_next      = '0;
                end
            end
            else
            begin
                case (count_reg) inside
                    [4'd1:4'd11]: xor_next = xor_reg ^ item.rx_byte;
                    default: ;
                endcase

                case (count_reg) inside
                    [4'd1:4'd3]: header_next[count_reg[1:0] - 2'd1] = item.rx_byte;
                    [4'd4:4'd8]: payload_next[3'(count_reg - 4'd4)] = item.rx_byte;
                    4'd12:       check_next = item.rx_byte;
                    default: ;
                endcase

                if (count_reg != LAST_POS)
                begin
                    count_next = count_reg + 4'd1;
                end
                else
                begin
                    // closing byte: XOR and check byte were settled on earlier beats
                    in_frame_next           = 1'b0;
                    count_next              = '0;
                    produce                 = 1'b1;
                    res_c.frame_source      = header_reg[0];
                    res_c.frame_destination = header_reg[1];
                    res_c.frame_command     = header_reg[2];
                    if (item.rx_byte != END_BYTE)
                        res_c.status = ST_NO_END;
                    else if (xor_reg != check_reg)
                        res_c.status = ST_CHECKSUM;
                    else if (!addr_match)
                        res_c.status = ST_OTHER;
                    else
                    begin
                        res_c.status             = ST_MATCH;
                        res_c.set_temperature    = temp_of(payload_reg[0]);
                        res_c.room_temperature   = temp_of(payload_reg[1]);
                        res_c.outlet_temperature = temp_of(payload_reg[2]);
                        res_c.fan_speed          = payload_reg[3][2:0];
                        res_c.swing_on           = (payload_reg[3][7:3] == SWING_BITS);
                        res_c.power_on           = payload_reg[4][7];
                        res_c.control_type       = payload_reg[4][3:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            xor_reg      <= '0;
            idle_reg     <= '0;
        end
        else if (advance)
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            xor_reg      <= xor_next;
            idle_reg     <= idle_next;
        end
    end

    // frame byte stores: written before any read, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            header_reg  <= header_next;
            payload_reg <= payload_next;
            check_reg   <= check_next;
        end
    end

    assign res_push = advance && produce;
    assign res      = res_c;

`ifndef SYNTHESIS
    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (count_reg == 4'd0))
        else $error("byte count nonzero outside a frame");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (count_reg >= 4'd1 && count_reg <= LAST_POS))
        else $error("byte count out of frame range");

    a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !in_frame_reg)
        else $error("frame still open after a result");
`endif

endmodule

// ===== rtl/dfr_result_buf.sv =====
// Two-entry result buffer: output register plus skid register.
// Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_result_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dfr_pkg::result_t  push_data,
    output logic              space,
    output logic              result_valid,
    input  logic              result_ready,
    output dfr_pkg::result_t  result
);
    import dfr_pkg::*;

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg,        out_next;
    result_t skid_reg,       skid_next;
    logic    pop;

    assign pop = out_valid_reg && result_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_next        = skid_valid_reg ? skid_reg : push_data;
            skid_valid_next = skid_valid_reg && push;
            skid_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign space        = !skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !skid_valid_reg && !push |=> !out_valid_reg)
        else $error("output still valid after last entry drained");
`endif

endmodule

// ===== rtl/delimited_frame_receiver_xor_decode.sv =====
// Delimited frame receiver with XOR check and field decode.
// Takes one beat per cycle while the result buffer has room (a serial byte or a millisecond tick);
// a 0x32 byte while idle opens a 14-byte frame, whose closing byte yields one result with status,
// header bytes and, for a good frame addressed to the match registers, the decoded temperatures,
// fan, swing, power and control type. A partial frame is dropped with a timeout result after
// timeout_ticks silent ticks. The input register feeds the frame engine; result_valid is registered
// in the buffer as the closing beat advances. A two-entry output buffer keeps input flowing while
// a result waits. Configuration must be written only while the block is idle, which the block
// does not enforce; cfg_ready is always high. Depends on dfr_pkg and the dfr_* submodules.
`timescale 1ns / 1ps

module delimited_frame_receiver_xor_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  dfr_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output dfr_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import dfr_pkg::*;

    logic    stage_valid_reg, stage_valid_next;
    item_t   stage_item_reg;
    logic    advance;
    logic    buf_space;
    logic    res_push;
    result_t res;
    cfg_t    cfg;

    // the staged beat moves on whenever the result buffer has room
    assign advance          = stage_valid_reg && buf_space;
    assign item_ready       = !stage_valid_reg || advance;
    assign stage_valid_next = (item_valid && item_ready) || (stage_valid_reg && !advance);
    assign cfg_ready        = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            stage_item_reg <= item;
    end

    dfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dfr_frame_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (stage_item_reg),
        .cfg      (cfg),
        .res_push (res_push),
        .res      (res)
    );

    dfr_result_buf u_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (res_push),
        .push_data    (res),
        .space        (buf_space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
